// File: design/bstf_pkg.sv
`default_nettype none
package bstf_pkg;

  localparam int unsigned SET_DEPTH  = 64;
  localparam int unsigned IDX_W      = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned ENTRY_W    = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_LEN_W  = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  // compare width: holds every cell index, SET_DEPTH itself and a raw length
  localparam int unsigned CMP_W      = (IDX_W + 1 > CFG_LEN_W) ? IDX_W + 1 : CFG_LEN_W;
  localparam int unsigned ENTRY_CMP_W = (CMP_W > ENTRY_W) ? CMP_W : ENTRY_W;

  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(SET_DEPTH);

  typedef enum logic [1:0] {
    MODE_DATA        = 2'd0,
    MODE_LOAD_FIRST  = 2'd1,
    MODE_LOAD_SECOND = 2'd2,
    MODE_NEW_STREAM  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELETE     = 3'd0,
    REG_COMPLEMENT = 3'd1,
    REG_SQUEEZE    = 3'd2,
    REG_FIRST_LEN  = 3'd3,
    REG_SECOND_LEN = 3'd4
  } cfg_reg_e;

  // lengths already clamped to SET_DEPTH
  typedef struct packed {
    logic             del;
    logic             cpl;
    logic             sqz;
    logic [CMP_W-1:0] len1;
    logic [CMP_W-1:0] len2;
  } cfg_t;

  // item travelling down the chain, with what the cells have found so far
  typedef struct packed {
    logic               vld;
    mode_e              mode;
    logic [ENTRY_W-1:0] idx;
    logic [BYTE_W-1:0]  b;
    logic               found;   // byte seen in first set
    logic [BYTE_W-1:0]  tr;      // second-set entry at first match
    logic               tr_ok;   // match position lies inside second set
    logic [BYTE_W-1:0]  cpl;     // second-set entry at first-set length
    logic               cpl_ok;
    logic [BYTE_W-1:0]  last2;   // last valid second-set entry
    logic               mem2;    // byte seen in second set
  } tok_t;

endpackage
`default_nettype wire

// File: design/bstf_in_if.sv
`default_nettype none
interface bstf_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [bstf_pkg::ENTRY_W-1:0]  entry_index;
  logic [bstf_pkg::BYTE_W-1:0]   byte_value;

  modport source (output valid, output mode, output entry_index, output byte_value,
                  input ready);
  modport sink   (input valid, input mode, input entry_index, input byte_value,
                  output ready);
endinterface
`default_nettype wire

// File: design/bstf_out_if.sv
`default_nettype none
interface bstf_out_if;
  logic                        valid;
  logic                        ready;
  logic [bstf_pkg::BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

// File: design/bstf_cell.sv
`default_nettype none
module bstf_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [bstf_pkg::CMP_W-1:0]  cell_idx_i,
  input  bstf_pkg::cfg_t              cfg_i,
  input  bstf_pkg::tok_t              tok_i,
  output bstf_pkg::tok_t              tok_o
);
  import bstf_pkg::*;

  logic [BYTE_W-1:0] first_q;
  logic [BYTE_W-1:0] second_q;
  logic              vld_q;
  tok_t              pay_q;
  tok_t              tok_d;
  logic              is_me;
  logic              is_data;
  logic              in1;
  logic              in2;

  assign is_me   = ENTRY_CMP_W'(tok_i.idx) == ENTRY_CMP_W'(cell_idx_i);
  assign is_data = tok_i.vld && (tok_i.mode == MODE_DATA);
  assign in1     = cell_idx_i < cfg_i.len1;
  assign in2     = cell_idx_i < cfg_i.len2;

  always_comb begin
    tok_d = tok_i;
    if (is_data) begin
      if (!tok_i.found && in1 && (first_q == tok_i.b)) begin
        tok_d.found = 1'b1;
        tok_d.tr    = second_q;
        tok_d.tr_ok = in2;
      end
      if (cell_idx_i == cfg_i.len1) begin
        tok_d.cpl    = second_q;
        tok_d.cpl_ok = in2;
      end
      if ((cfg_i.len2 != '0) && (cell_idx_i == cfg_i.len2 - 1'b1)) begin
        tok_d.last2 = second_q;
      end
      if (in2 && (second_q == tok_i.b)) begin
        tok_d.mem2 = 1'b1;
      end
    end
  end

  // set entries: written as a load item passes this cell
  always_ff @(posedge clk_i) begin
    if (adv_i && tok_i.vld && is_me) begin
      if (tok_i.mode == MODE_LOAD_FIRST) begin
        first_q <= tok_i.b;
      end
      if (tok_i.mode == MODE_LOAD_SECOND) begin
        second_q <= tok_i.b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pay_q <= tok_d;
    end
  end

  always_comb begin
    tok_o     = pay_q;
    tok_o.vld = vld_q;
  end

endmodule
`default_nettype wire

// File: design/bstf_tail.sv
`default_nettype none
module bstf_tail (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bstf_pkg::cfg_t  cfg_i,
  input  bstf_pkg::tok_t  tok_i,
  output logic            adv_o,
  bstf_out_if.source      out_o
);
  import bstf_pkg::*;

  logic              out_vld_q;
  logic              out_vld_d;
  logic [BYTE_W-1:0] out_byte_q;
  logic [BYTE_W-1:0] last_q;
  logic [BYTE_W-1:0] last_d;
  logic              last_vld_q;
  logic              last_vld_d;
  logic              is_data;
  logic              match;
  logic              xlate;
  logic              member;
  logic              squeeze;
  logic              emit;
  logic [BYTE_W-1:0] val;

  assign adv_o = !out_vld_q || out_o.ready;

  assign is_data = tok_i.vld && (tok_i.mode == MODE_DATA);
  assign match   = tok_i.found ^ cfg_i.cpl;
  assign xlate   = !cfg_i.del && match && (cfg_i.len2 != '0);

  always_comb begin
    val = tok_i.b;
    if (xlate) begin
      if (cfg_i.cpl) begin
        val = tok_i.cpl_ok ? tok_i.cpl : tok_i.last2;
      end else begin
        val = tok_i.tr_ok ? tok_i.tr : tok_i.last2;
      end
    end
  end

  // a translated byte is a second-set entry by construction
  assign member  = xlate || tok_i.mem2;
  assign squeeze = cfg_i.sqz && last_vld_q && (val == last_q) && member;
  assign emit    = is_data && (cfg_i.del ? !match : !squeeze);

  always_comb begin
    out_vld_d  = out_vld_q;
    last_d     = last_q;
    last_vld_d = last_vld_q;
    if (adv_o) begin
      out_vld_d = emit;
      if (emit) begin
        last_d     = val;
        last_vld_d = 1'b1;
      end else if (tok_i.vld && (tok_i.mode == MODE_NEW_STREAM)) begin
        last_d     = '0;
        last_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      last_q     <= '0;
      last_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      last_q     <= last_d;
      last_vld_q <= last_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && emit) begin
      out_byte_q <= val;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.out_byte = out_byte_q;

  a_new_stream_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_o && tok_i.vld && (tok_i.mode == MODE_NEW_STREAM)) |=> !last_vld_q)
    else $error("new stream item left last byte valid");

  a_emit_tracks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_o && emit) |=> (out_vld_q && last_vld_q && (last_q == out_byte_q)))
    else $error("emitted byte not recorded as last byte");

  a_load_keeps_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_o && tok_i.vld &&
     ((tok_i.mode == MODE_LOAD_FIRST) || (tok_i.mode == MODE_LOAD_SECOND)))
    |=> ($stable(last_q) && $stable(last_vld_q) && !out_vld_q))
    else $error("load item disturbed the output side");

endmodule
`default_nettype wire

// File: design/byte_set_translate_filter.sv
`default_nettype none
// Byte stream filter in the style of tr: delete, translate and squeeze against two
// character sets of SET_DEPTH entries. Load items fill the sets, data items are
// filtered and a new-stream item forgets the last emitted byte; all of them travel
// the same chain of cells, one cell per cycle, so loads and data keep their order.
// The block takes one item per cycle; each item is registered in every cell of the
// chain and then in the output register. The whole chain stalls while the output
// register holds an item that is not taken. Set entries never loaded since reset
// read as unknown. Configuration is to be written by the user while no item is in
// flight; the block does not enforce it. Lengths over SET_DEPTH count as SET_DEPTH.
module byte_set_translate_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bstf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bstf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bstf_in_if.sink                         in_i,
  bstf_out_if.source                      out_o
);
  import bstf_pkg::*;

  logic                 del_q;
  logic                 cpl_q;
  logic                 sqz_q;
  logic [CFG_LEN_W-1:0] len1_q;
  logic [CFG_LEN_W-1:0] len2_q;
  cfg_t                 cfg;
  logic                 adv;
  tok_t                 chain_head;
  tok_t                 chain [SET_DEPTH+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      del_q  <= 1'b0;
      cpl_q  <= 1'b0;
      sqz_q  <= 1'b0;
      len1_q <= '0;
      len2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELETE:     del_q  <= cfg_data_i[0];
        REG_COMPLEMENT: cpl_q  <= cfg_data_i[0];
        REG_SQUEEZE:    sqz_q  <= cfg_data_i[0];
        REG_FIRST_LEN:  len1_q <= cfg_data_i[CFG_LEN_W-1:0];
        REG_SECOND_LEN: len2_q <= cfg_data_i[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.del  = del_q;
    cfg.cpl  = cpl_q;
    cfg.sqz  = sqz_q;
    cfg.len1 = (CMP_W'(len1_q) > DEPTH_C) ? DEPTH_C : CMP_W'(len1_q);
    cfg.len2 = (CMP_W'(len2_q) > DEPTH_C) ? DEPTH_C : CMP_W'(len2_q);
  end

  assign in_i.ready = adv;

  always_comb begin
    chain_head      = '0;
    chain_head.vld  = in_i.valid && adv;
    chain_head.mode = mode_e'(in_i.mode);
    chain_head.idx  = in_i.entry_index;
    chain_head.b    = in_i.byte_value;
  end

  assign chain[0] = chain_head;

  for (genvar k = 0; k < SET_DEPTH; k++) begin : g_cell
    bstf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (CMP_W'(k)),
      .cfg_i      (cfg),
      .tok_i      (chain[k]),
      .tok_o      (chain[k+1])
    );
  end

  bstf_tail u_tail (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .tok_i  (chain[SET_DEPTH]),
    .adv_o  (adv),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire
